// ===== rtl/isotp_tx_pkg.sv =====
// Types, constants and frame packing shared by the ISO-TP transmit segmenter.
package isotp_tx_pkg;

  localparam logic [7:0]  PAD_BYTE      = 8'h55;
  localparam logic [55:0] PAD_56        = {7{PAD_BYTE}};
  localparam logic [7:0]  NR_SID        = 8'h7F;
  localparam logic [7:0]  NR_CODE       = 8'h10;
  localparam logic [7:0]  NR_LEN        = 8'h03;
  localparam logic [7:0]  SID_OFFSET    = 8'h40;
  localparam logic [3:0]  PCI_FIRST     = 4'h1;
  localparam logic [3:0]  PCI_CONSEC    = 4'h2;
  localparam logic [7:0]  FC_CONTINUE   = 8'h30;
  localparam logic [7:0]  FC_OVERFLOW   = 8'h32;
  localparam logic [7:0]  SEQ_START     = 8'h01;
  localparam logic [2:0]  FIRST_BYTES   = 3'd6;
  localparam logic [2:0]  CONSEC_BYTES  = 3'd7;
  localparam logic [15:0] SINGLE_MAX    = 16'd7;

  localparam logic [2:0] KIND_SINGLE = 3'd0;
  localparam logic [2:0] KIND_FIRST  = 3'd1;
  localparam logic [2:0] KIND_CONSEC = 3'd2;
  localparam logic [2:0] KIND_FC     = 3'd3;
  localparam logic [2:0] KIND_NR     = 3'd4;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_FIRST  = 2'd2;
  localparam logic [1:0] MODE_CONSEC = 2'd3;

  localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] REG_SEP_TIME   = 2'd1;

  typedef struct packed {
    logic [63:0] frame;
    logic [2:0]  kind;
    logic        done;
  } result_t;

  // Header byte, the n newest collected bytes, then padding.
  function automatic logic [63:0] pack_frame(input logic [7:0] hdr, input logic [55:0] asm,
                                             input logic [2:0] n);
    logic [5:0]  dshift;
    logic [5:0]  pshift;
    logic [55:0] datamask;
    logic [55:0] padmask;
    logic [55:0] body;
    dshift   = {n, 3'b000};
    pshift   = {3'd7 - n, 3'b000};
    datamask = ~({56{1'b1}} << dshift);
    padmask  = {56{1'b1}} >> dshift;
    body     = ((asm & datamask) << pshift) | (PAD_56 & padmask);
    return {hdr, body};
  endfunction

endpackage

// ===== rtl/isotp_tx_segmenter_top.sv =====
// ISO-TP transmit segmenter: message bytes in, CAN frames out.
// One request is taken per cycle while in_stall is low, and any frame it makes is registered
// into the output register or, while the output is stalled, into the one-entry skid stage
// behind it. All segmentation work is a single registered step. Input stalls from the cycle
// after a frame enters the skid stage until the cycle after the output register is next read.
// Until the skid stage fills, requests keep flowing under an output stall.
module isotp_tx_segmenter_top
  import isotp_tx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  input  logic [15:0] in_message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_frame,
  output logic [2:0]  out_frame_kind,
  output logic        out_message_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]  block_size_r;
  logic [7:0]  sep_time_r;
  logic [55:0] asm_r, asm_nxt;
  logic [2:0]  bif_r, bif_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [11:0] hlen_r, hlen_nxt;
  result_t     res;
  logic        res_valid;
  result_t     out_r, skid_r;
  logic        out_valid_r, skid_valid_r;
  logic        acc;
  logic        pop;
  logic        collect;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign acc       = in_valid && !in_stall;
  assign pop       = out_valid_r && !out_stall;

  always_comb begin
    asm_nxt   = asm_r;
    bif_nxt   = bif_r;
    rem_nxt   = rem_r;
    seq_nxt   = seq_r;
    mode_nxt  = mode_r;
    hlen_nxt  = hlen_r;
    res       = '0;
    res_valid = 1'b0;
    collect   = 1'b0;
    if (in_action) begin
      res.frame = {(seq_r > block_size_r) ? FC_OVERFLOW : FC_CONTINUE, block_size_r, sep_time_r,
                   PAD_56[39:0]};
      res.kind  = KIND_FC;
      res_valid = 1'b1;
      seq_nxt   = SEQ_START;
    end else if (in_start_of_message) begin
      asm_nxt = '0;
      bif_nxt = '0;
      if (|in_message_length[15:12]) begin
        res.frame = {NR_LEN, NR_SID, in_data_byte - SID_OFFSET, NR_CODE, PAD_56[31:0]};
        res.kind  = KIND_NR;
        res.done  = 1'b1;
        res_valid = 1'b1;
        mode_nxt  = MODE_IDLE;
        rem_nxt   = '0;
      end else if (in_message_length == 16'd0) begin
        hlen_nxt  = '0;
        res.frame = {8'h00, PAD_56};
        res.kind  = KIND_SINGLE;
        res.done  = 1'b1;
        res_valid = 1'b1;
        mode_nxt  = MODE_IDLE;
        rem_nxt   = '0;
      end else begin
        hlen_nxt = in_message_length[11:0];
        rem_nxt  = in_message_length;
        mode_nxt = (in_message_length <= SINGLE_MAX) ? MODE_SINGLE : MODE_FIRST;
        collect  = 1'b1;
      end
    end else if (mode_r != MODE_IDLE) begin
      collect = 1'b1;
    end

    if (collect) begin
      asm_nxt = {asm_nxt[47:0], in_data_byte};
      bif_nxt = bif_nxt + 3'd1;
      rem_nxt = rem_nxt - 16'd1;
      unique case (mode_nxt)
        MODE_SINGLE: begin
          if (rem_nxt == 16'd0) begin
            res.frame = pack_frame(hlen_nxt[7:0], asm_nxt, bif_nxt);
            res.kind  = KIND_SINGLE;
            res.done  = 1'b1;
            res_valid = 1'b1;
            mode_nxt  = MODE_IDLE;
            bif_nxt   = '0;
          end
        end
        MODE_FIRST: begin
          if (bif_nxt == FIRST_BYTES) begin
            res.frame = {PCI_FIRST, hlen_nxt, asm_nxt[47:0]};
            res.kind  = KIND_FIRST;
            res_valid = 1'b1;
            mode_nxt  = MODE_CONSEC;
            bif_nxt   = '0;
            asm_nxt   = '0;
          end
        end
        MODE_CONSEC: begin
          if (bif_nxt == CONSEC_BYTES || rem_nxt == 16'd0) begin
            res.frame = pack_frame({PCI_CONSEC, seq_r[3:0]}, asm_nxt, bif_nxt);
            res.kind  = KIND_CONSEC;
            res.done  = (rem_nxt == 16'd0);
            res_valid = 1'b1;
            seq_nxt   = seq_r + 8'd1;
            bif_nxt   = '0;
            asm_nxt   = '0;
            if (rem_nxt == 16'd0) begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= '0;
      sep_time_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BLOCK_SIZE) begin
        block_size_r <= cfg_wdata;
      end else if (cfg_index == REG_SEP_TIME) begin
        sep_time_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r  <= '0;
      bif_r  <= '0;
      rem_r  <= '0;
      seq_r  <= SEQ_START;
      mode_r <= MODE_IDLE;
      hlen_r <= '0;
    end else if (acc) begin
      asm_r  <= asm_nxt;
      bif_r  <= bif_nxt;
      rem_r  <= rem_nxt;
      seq_r  <= seq_nxt;
      mode_r <= mode_nxt;
      hlen_r <= hlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= acc && res_valid;
      end else begin
        out_valid_r <= acc && res_valid;
      end
    end else if (acc && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (acc && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame        = out_r.frame;
  assign out_frame_kind   = out_r.kind;
  assign out_message_done = out_r.done;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with output register empty");

  a_single_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SINGLE) |-> (rem_r != 16'd0 && rem_r <= SINGLE_MAX))
    else $error("single frame mode with bad remaining count");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (bif_r == 3'd0))
    else $error("bytes collected while idle");

  a_fc_resets_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_action) |=> (seq_r == SEQ_START))
    else $error("sequence count not restarted by flow control");

endmodule

// ===== test/isotp_tx_segmenter_top_tb.sv =====
// Self-checking testbench for the ISO-TP transmit segmenter: directed and random byte streams.
module isotp_tx_segmenter_top_tb;
  import isotp_tx_pkg::*;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LONG_HOLD_AFTER  = 350;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PHASE_ITEMS      = 170;
  localparam int PHASES           = 5;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam logic       ACT_DATA    = 1'b0;
  localparam logic       ACT_FLOW    = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic        start;
    logic [15:0] length;
  } seg_request_t;

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        in_valid            = 1'b0;
  logic        in_stall;
  logic        in_action           = 1'b0;
  logic [7:0]  in_data_byte        = 8'h00;
  logic        in_start_of_message = 1'b0;
  logic [15:0] in_message_length   = 16'h0000;
  logic        out_valid;
  logic        out_stall           = 1'b0;
  logic [63:0] out_frame;
  logic [2:0]  out_frame_kind;
  logic        out_message_done;
  logic        cfg_valid           = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index           = 2'd0;
  logic [7:0]  cfg_wdata           = 8'h00;

  seg_request_t pending_requests[$];
  result_t      expected_frames[$];
  seg_request_t in_flight;

  // Segmenter state mirror
  logic [55:0] seg_asm       = '0;
  logic [2:0]  seg_fill      = '0;
  logic [15:0] seg_left      = '0;
  logic [7:0]  seg_seq       = SEQ_START;
  logic [1:0]  seg_mode      = MODE_IDLE;
  logic [11:0] seg_len       = '0;
  logic [7:0]  fc_block_size = 8'h00;
  logic [7:0]  fc_sep_time   = 8'h00;

  int  queued_total   = 0;
  int  accepted_total = 0;
  int  useful_items   = 0;
  int  mismatches     = 0;
  int  send_gap       = 0;
  int  recv_gap       = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;
  int  quiet_cycles   = 0;
  bit  idle_enabled   = 1'b1;

  isotp_tx_segmenter_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .in_message_length   (in_message_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame           (out_frame),
    .out_frame_kind      (out_frame_kind),
    .out_message_done    (out_message_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Header, the n newest bytes in arrival order, then padding
  function automatic logic [63:0] pad_frame(input logic [7:0] hdr, input int n);
    logic [55:0] body;
    body = PAD_56;
    for (int i = 0; i < n; i++) body[55 - 8 * i -: 8] = seg_asm[8 * (n - 1 - i) +: 8];
    return {hdr, body};
  endfunction

  task automatic segment_request(input seg_request_t req);
    result_t res;
    logic    emit;
    logic    last;
    res  = '0;
    emit = 1'b0;
    if (req.action == ACT_FLOW) begin
      res  = '{{(seg_seq > fc_block_size) ? FC_OVERFLOW : FC_CONTINUE, fc_block_size,
                fc_sep_time, {5{PAD_BYTE}}}, KIND_FC, 1'b0};
      emit = 1'b1;
      seg_seq = SEQ_START;
    end else if (req.start && req.length > 16'h0FFF) begin
      seg_asm  = '0;
      seg_fill = '0;
      seg_left = '0;
      seg_mode = MODE_IDLE;
      res  = '{{NR_LEN, NR_SID, req.data_byte - SID_OFFSET, NR_CODE, {4{PAD_BYTE}}},
               KIND_NR, 1'b1};
      emit = 1'b1;
    end else if (req.start && req.length == 16'h0000) begin
      seg_asm  = '0;
      seg_fill = '0;
      seg_left = '0;
      seg_len  = '0;
      seg_mode = MODE_IDLE;
      res  = '{pad_frame(8'h00, 0), KIND_SINGLE, 1'b1};
      emit = 1'b1;
    end else if (req.start || seg_mode != MODE_IDLE) begin
      if (req.start) begin
        seg_asm  = '0;
        seg_fill = '0;
        seg_len  = req.length[11:0];
        seg_left = req.length;
        seg_mode = (req.length <= SINGLE_MAX) ? MODE_SINGLE : MODE_FIRST;
      end
      seg_asm  = {seg_asm[47:0], req.data_byte};
      seg_fill = seg_fill + 3'd1;
      seg_left = seg_left - 16'd1;
      case (seg_mode)
        MODE_SINGLE: begin
          if (seg_left == 16'd0) begin
            res  = '{pad_frame(seg_len[7:0], int'(seg_fill)), KIND_SINGLE, 1'b1};
            emit = 1'b1;
            seg_mode = MODE_IDLE;
            seg_fill = '0;
          end
        end
        MODE_FIRST: begin
          if (seg_fill == FIRST_BYTES) begin
            res  = '{{PCI_FIRST, seg_len, seg_asm[47:0]}, KIND_FIRST, 1'b0};
            emit = 1'b1;
            seg_mode = MODE_CONSEC;
            seg_fill = '0;
            seg_asm  = '0;
          end
        end
        default: begin
          if (seg_fill == CONSEC_BYTES || seg_left == 16'd0) begin
            last = (seg_left == 16'd0);
            res  = '{pad_frame({PCI_CONSEC, seg_seq[3:0]}, int'(seg_fill)), KIND_CONSEC, last};
            emit = 1'b1;
            seg_seq  = seg_seq + 8'd1;
            seg_fill = '0;
            seg_asm  = '0;
            if (last) seg_mode = MODE_IDLE;
          end
        end
      endcase
    end
    if (emit) expected_frames.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        segment_request(in_flight);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_flight = pending_requests.pop_front();
          in_valid            <= 1'b1;
          in_action           <= in_flight.action;
          in_data_byte        <= in_flight.data_byte;
          in_start_of_message <= in_flight.start;
          in_message_length   <= in_flight.length;
          send_gap = idle_enabled ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected frame %h kind %0d done %b",
                     out_frame, out_frame_kind, out_message_done);
        end else begin
          want = expected_frames.pop_front();
          if (out_frame !== want.frame || out_frame_kind !== want.kind ||
              out_message_done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame mismatch: expected %h kind %0d done %b, got %h kind %0d done %b",
                       want.frame, want.kind, want.done,
                       out_frame, out_frame_kind, out_message_done);
          end
        end
      end
      // one long hold-off mid-run so the block backs up and stalls its input
      if (!long_hold_done && accepted_total >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD_CYCLES;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap = idle_enabled ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_request(input logic act, input logic [7:0] data, input logic start,
                               input logic [15:0] len);
    pending_requests.push_back('{act, data, start, len});
    queued_total++;
  endtask

  task automatic queue_flow_control();
    queue_request(ACT_FLOW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
    useful_items++;
  endtask

  task automatic queue_message(input int len, input int count, input int fc_rate);
    for (int i = 0; i < count; i++) begin
      if (i > 0 && $urandom_range(0, 99) < fc_rate) queue_flow_control();
      queue_request(ACT_DATA, 8'($urandom_range(0, 255)), i == 0,
                    16'((i == 0) ? len : $urandom_range(0, 65535)));
    end
    useful_items += count;
  endtask

  task automatic queue_idle_bytes(input int count);
    for (int i = 0; i < count; i++)
      queue_request(ACT_DATA, 8'($urandom_range(0, 255)), 1'b0,
                    16'($urandom_range(0, 65535)));
  endtask

  task automatic queue_random_traffic();
    int pick;
    int len;
    int fc_rate;
    pick    = $urandom_range(0, 99);
    fc_rate = ($urandom_range(0, 1) == 0) ? 0 : 4;
    if ($urandom_range(0, 9) == 0) queue_flow_control();
    if (pick < 40) begin
      len = $urandom_range(1, 7);
      queue_message(len, len, fc_rate);
    end else if (pick < 62) begin
      len = $urandom_range(8, 60);
      queue_message(len, len, fc_rate);
    end else if (pick < 67) begin
      len = $urandom_range(61, 300);
      queue_message(len, len, fc_rate);
    end else if (pick < 72) begin
      queue_message($urandom_range(301, 4095), $urandom_range(8, 40), fc_rate);
    end else if (pick < 78) begin
      queue_message($urandom_range(4096, 65535), 1, 0);
      queue_idle_bytes($urandom_range(0, 3));
    end else if (pick < 82) begin
      queue_message(0, 1, 0);
    end else if (pick < 88) begin
      len = $urandom_range(2, 120);
      queue_message(len, $urandom_range(1, len - 1), fc_rate);
    end else if (pick < 94) begin
      queue_idle_bytes($urandom_range(1, 3));
    end else begin
      queue_flow_control();
    end
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BLOCK_SIZE) fc_block_size = value;
    else if (idx == REG_SEP_TIME) fc_sep_time = value;
  endtask

  task automatic set_limits(input logic [7:0] blk, input logic [7:0] st);
    program_register(REG_BLOCK_SIZE, blk);
    program_register(REG_SEP_TIME, st);
    program_register(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                     8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (accepted_total != queued_total || expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_limits(8'h00, 8'h00);

    // zero length, flow control, stray byte, too-long messages and a dropped byte
    queue_request(ACT_DATA, 8'hFF, 1'b1, 16'h0000);
    queue_request(ACT_FLOW, 8'hAA, 1'b1, 16'hFFFF);
    queue_request(ACT_DATA, 8'h5A, 1'b0, 16'h0003);
    queue_request(ACT_DATA, 8'h00, 1'b1, 16'hFFFF);
    queue_request(ACT_DATA, 8'hFF, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'h22, 1'b1, 16'h1000);
    // full single frame
    queue_request(ACT_DATA, 8'h00, 1'b1, 16'h0007);
    queue_request(ACT_DATA, 8'hFF, 1'b0, 16'hFFFF);
    queue_request(ACT_DATA, 8'h01, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'h80, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'h7F, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'h10, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'hEE, 1'b0, 16'h0000);
    // new start abandons a message in progress
    queue_request(ACT_DATA, 8'h11, 1'b1, 16'h0005);
    queue_request(ACT_DATA, 8'h12, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'h21, 1'b1, 16'h0002);
    queue_request(ACT_DATA, 8'h22, 1'b0, 16'h0000);
    // first frame plus a short consecutive frame, flow control in between
    queue_request(ACT_DATA, 8'hA0, 1'b1, 16'h0008);
    for (int i = 1; i < 6; i++) queue_request(ACT_DATA, 8'(8'hA0 + i), 1'b0, 16'h0000);
    queue_request(ACT_FLOW, 8'h00, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'hB6, 1'b0, 16'h0000);
    queue_request(ACT_DATA, 8'hB7, 1'b0, 16'h0000);
    useful_items = queued_total;
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_limits(8'hFF, 8'hFF);
        1:       set_limits(8'($urandom_range(1, 6)), 8'($urandom_range(0, 255)));
        2:       set_limits(8'($urandom_range(0, 255)), 8'h00);
        3:       set_limits(8'h02, 8'($urandom_range(0, 255)));
        default: set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      idle_enabled = (phase != 3);
      for (int target = useful_items + PHASE_ITEMS; useful_items < target; )
        queue_random_traffic();
      wait_drained();
    end

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
